[hdl/tps_pkg.sv]
// Shared types, constants and the byte classifier of the text pre-token splitter.
// Used by tps_front, tps_queue, tps_back and text_pretokenizer_splitter.
// Depends on nothing else.
package tps_pkg;

  localparam int unsigned GroupMax   = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_SPACE  = 3'd1,
    KIND_LETTER = 3'd2,
    KIND_DIGIT  = 3'd3,
    KIND_OTHER  = 3'd4,
    KIND_APOS   = 3'd5
  } kind_e;

  // Every result item that one text item causes, in release order.
  typedef struct packed {
    logic [1:0]                count;
    logic [GroupMax-1:0][7:0]  bytes;
    logic [GroupMax-1:0]       starts;
    logic                      text_end;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic kind_e byte_class(input logic [7:0] b);
    kind_e k;
    if (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
      k = KIND_SPACE;
    end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b[7]) begin
      k = KIND_LETTER;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      k = KIND_DIGIT;
    end else if (b == 8'h27) begin
      k = KIND_APOS;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

[hdl/tps_front.sv]
// Front end of the splitter: classifies each text item, tracks the open run and
// the pending contraction, and builds the group of result items it releases.
// Depends on tps_pkg.
module tps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          text_byte_i,
  input  logic                text_last_i,
  output logic                push_o,
  output tps_pkg::group_t     group_o
);

  typedef enum logic [2:0] {
    PH_NONE = 3'd0,
    PH_APOS = 3'd1,
    PH_R    = 3'd2,
    PH_V    = 3'd3,
    PH_L    = 3'd4
  } phase_e;

  localparam logic [7:0] ChS = 8'h73;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChM = 8'h6D;
  localparam logic [7:0] ChD = 8'h64;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChV = 8'h76;
  localparam logic [7:0] ChL = 8'h6C;
  localparam logic [7:0] ChE = 8'h65;

  tps_pkg::kind_e prev_kind_q, prev_kind_d;
  phase_e         phase_q, phase_d;
  logic [7:0]     held0_q, held0_d, held1_q, held1_d;

  always_comb begin
    tps_pkg::kind_e k;
    logic [7:0]     want;
    logic           fail;
    logic           feed;
    logic [1:0]     n;
    k           = tps_pkg::byte_class(text_byte_i);
    want        = (phase_q == PH_L) ? ChL : ChE;
    fail        = 1'b0;
    feed        = 1'b0;
    n           = 2'd0;
    prev_kind_d = prev_kind_q;
    phase_d     = phase_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    group_o     = '0;

    unique case (phase_q)
      PH_NONE: begin
        feed = 1'b1;
      end
      PH_APOS: begin
        if (text_byte_i == ChS || text_byte_i == ChT || text_byte_i == ChM ||
            text_byte_i == ChD) begin
          group_o.bytes[n] = held0_q; group_o.starts[n] = 1'b1; n = n + 2'd1;
          group_o.bytes[n] = text_byte_i; group_o.starts[n] = 1'b0; n = n + 2'd1;
          prev_kind_d = tps_pkg::KIND_NONE;
          phase_d     = PH_NONE;
        end else if (text_byte_i == ChR || text_byte_i == ChV || text_byte_i == ChL) begin
          held1_d = text_byte_i;
          phase_d = (text_byte_i == ChR) ? PH_R : ((text_byte_i == ChV) ? PH_V : PH_L);
        end else begin
          fail = 1'b1;
          feed = 1'b1;
        end
      end
      default: begin
        if (text_byte_i == want) begin
          group_o.bytes[n] = held0_q; group_o.starts[n] = 1'b1; n = n + 2'd1;
          group_o.bytes[n] = held1_q; group_o.starts[n] = 1'b0; n = n + 2'd1;
          group_o.bytes[n] = text_byte_i; group_o.starts[n] = 1'b0; n = n + 2'd1;
          prev_kind_d = tps_pkg::KIND_NONE;
          phase_d     = PH_NONE;
        end else begin
          fail = 1'b1;
          feed = 1'b1;
        end
      end
    endcase

    // A failed contraction releases the apostrophe, then any held letter.
    if (fail) begin
      group_o.bytes[n] = held0_q; group_o.starts[n] = 1'b1; n = n + 2'd1;
      prev_kind_d = tps_pkg::KIND_OTHER;
      if (phase_q != PH_APOS) begin
        group_o.bytes[n] = held1_q; group_o.starts[n] = 1'b1; n = n + 2'd1;
        prev_kind_d = tps_pkg::KIND_LETTER;
      end
      phase_d = PH_NONE;
    end

    if (feed) begin
      if (k == tps_pkg::KIND_APOS) begin
        held0_d = text_byte_i;
        phase_d = PH_APOS;
      end else begin
        group_o.bytes[n]  = text_byte_i;
        group_o.starts[n] = (prev_kind_d != k);
        n = n + 2'd1;
        prev_kind_d = k;
      end
    end

    // End of text flushes whatever is still held and starts a fresh text.
    if (text_last_i) begin
      if (phase_d != PH_NONE) begin
        group_o.bytes[n] = held0_d; group_o.starts[n] = 1'b1; n = n + 2'd1;
        if (phase_d != PH_APOS) begin
          group_o.bytes[n] = held1_d; group_o.starts[n] = 1'b1; n = n + 2'd1;
        end
      end
      prev_kind_d = tps_pkg::KIND_NONE;
      phase_d     = PH_NONE;
    end

    group_o.count    = n;
    group_o.text_end = text_last_i;
  end

  assign push_o = accept_i && (group_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_kind_q <= tps_pkg::KIND_NONE;
      phase_q     <= PH_NONE;
    end else if (accept_i) begin
      prev_kind_q <= prev_kind_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

[hdl/tps_queue.sv]
// Short queue of result groups between the front end and the back end.
// Depends on tps_pkg.
module tps_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tps_pkg::group_t       push_group_i,
  input  logic                  pop_i,
  output tps_pkg::group_t       head_o,
  output tps_pkg::queue_status_t status_o
);

  tps_pkg::group_t                   mem_q [tps_pkg::QueueDepth];
  logic [tps_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [tps_pkg::QueueCntW-1:0]     count_q;

  assign status_o.full  = (count_q == tps_pkg::QueueCntW'(tps_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

endmodule

[hdl/tps_back.sv]
// Back end of the splitter: walks the head group of the queue and sends its
// result items one per cycle unless stalled, via a registered output stage.
// Depends on tps_pkg.
module tps_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tps_pkg::group_t        head_i,
  input  tps_pkg::queue_status_t status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   token_start_o,
  output logic                   run_last_o,
  output logic                   text_end_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic       load;
  logic       is_last;
  logic [7:0] byte_q;
  logic       start_q, run_last_q, text_end_q;

  assign load    = !status_i.empty && (!valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.count - 2'd1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= head_i.bytes[idx_q];
      start_q    <= head_i.starts[idx_q];
      run_last_q <= is_last;
      text_end_q <= is_last && head_i.text_end;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign token_start_o = start_q;
  assign run_last_o    = run_last_q;
  assign text_end_o    = text_end_q;

endmodule

[hdl/text_pretokenizer_splitter.sv]
// Top level of the text pre-token splitter: front end, group queue, back end.
// Depends on tps_pkg, tps_front, tps_queue and tps_back.
//
//  Channel  Direction  Handshake              Payload
//  input    in         in_valid_i/in_stall_o  text_byte_i, text_last_i
//  output   out        out_valid_o/out_stall_i out_byte_o, token_start_o,
//                                               run_last_o, text_end_o
//
// A text item is taken in every cycle while the group queue (four groups) has
// room; its zero to three result items are worked out in that same cycle.
// Result items leave one per cycle unless stalled, from a registered output
// stage, so the output side, one result item a cycle, sets the sustained rate.
// Reset is asynchronous and active low; it empties the queue and clears the
// run and contraction state, so the next item begins a fresh text.
// A stall at the output fills the queue; the input stalls only when it is full.
module text_pretokenizer_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       text_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       token_start_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  tps_pkg::group_t        front_group;
  tps_pkg::group_t        head_group;
  tps_pkg::queue_status_t queue_status;
  logic                   accept;
  logic                   push;
  logic                   pop;

  // The front end is held off only by a full queue, so the stall never looks
  // at the incoming valid.
  assign in_stall_o = queue_status.full;
  assign accept     = in_valid_i && !queue_status.full;

  tps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .text_last_i (text_last_i),
    .push_o      (push),
    .group_o     (front_group)
  );

  // An item that only extends a held contraction makes an empty group, which
  // is never queued.
  tps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (front_group),
    .pop_i        (pop),
    .head_o       (head_group),
    .status_o     (queue_status)
  );

  tps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_group),
    .status_i      (queue_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .token_start_o (token_start_o),
    .run_last_o    (run_last_o),
    .text_end_o    (text_end_o)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the text pre-token splitter (text_pretokenizer_splitter).
// It drives text bytes, predicts the released bytes and token-start flags in its own
// model and checks every result item. It depends on tps_pkg and the splitter RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  // Registered output stage behind a four-group queue: the drain wait covers
  // anything still in flight once the last expected result item has arrived.
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 60;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 40;

  localparam logic [7:0] APOSTROPHE = 8'h27;

  // Contraction progress of the predictor: which bytes are being held back.
  typedef enum logic [2:0] {
    PH_NONE,
    PH_APOS,
    PH_APOS_R,
    PH_APOS_V,
    PH_APOS_L
  } hold_phase_e;

  // The kinds of fragment that random texts are assembled from.
  typedef enum logic [2:0] {
    FRAG_SPACE,
    FRAG_WORD,
    FRAG_NUMBER,
    FRAG_PUNCT,
    FRAG_CONTRACTION,
    FRAG_BROKEN,
    FRAG_NOISE
  } fragment_e;

  // One released byte as the block should present it.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       starts_token;
    logic       run_last;
    logic       text_end;
  } split_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       text_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       token_start_o;
  logic       run_last_o;
  logic       text_end_o;

  // Predictor state: the class of the open run and the bytes held for a contraction.
  tps_pkg::kind_e open_kind       = tps_pkg::KIND_NONE;
  hold_phase_e    hold_phase      = PH_NONE;
  logic [7:0]     held_apostrophe = 8'h00;
  logic [7:0]     held_letter     = 8'h00;

  split_result_t step_pieces[$];
  split_result_t expected_pieces[$];
  logic [7:0]    text_bytes[$];

  string contraction_suffix[7] = '{"s", "t", "re", "ve", "m", "ll", "d"};

  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;

  // Idling controls for the sender task and the receiver process.
  logic send_gaps   = 1'b1;
  logic recv_stalls = 1'b1;
  logic hold_output = 1'b0;

  text_pretokenizer_splitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .text_last_i   (text_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .token_start_o (token_start_o),
    .run_last_o    (run_last_o),
    .text_end_o    (text_end_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Byte classes: bit 7 set counts as a letter; folding bit 5 in maps upper case
  // onto lower case, so a single range check catches both cases of A to Z.
  function automatic tps_pkg::kind_e classify_byte(input logic [7:0] b);
    logic [7:0]     folded;
    tps_pkg::kind_e k;
    folded = b | 8'h20;
    k      = tps_pkg::KIND_OTHER;
    if (b == APOSTROPHE) begin
      k = tps_pkg::KIND_APOS;
    end else if (b >= "0" && b <= "9") begin
      k = tps_pkg::KIND_DIGIT;
    end else if (b[7] || (folded >= "a" && folded <= "z")) begin
      k = tps_pkg::KIND_LETTER;
    end else if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
      k = tps_pkg::KIND_SPACE;
    end
    return k;
  endfunction

  function automatic void add_piece(input logic [7:0] b, input logic starts);
    split_result_t piece;
    piece.text_byte    = b;
    piece.starts_token = starts;
    piece.run_last     = 1'b0;
    piece.text_end     = 1'b0;
    step_pieces.insert(step_pieces.size(), piece);
  endfunction

  // A byte outside any contraction: an apostrophe is held, anything else is
  // released and starts a token whenever its class differs from the open run.
  function automatic void take_plain_byte(input logic [7:0] b);
    tps_pkg::kind_e k;
    k = classify_byte(b);
    if (k == tps_pkg::KIND_APOS) begin
      held_apostrophe = b;
      hold_phase      = PH_APOS;
    end else begin
      add_piece(b, open_kind != k);
      open_kind = k;
    end
  endfunction

  // A contraction that did not happen: the apostrophe stands alone as an other
  // token, and a held r, v or l then opens a letter run.
  function automatic void release_held_bytes();
    add_piece(held_apostrophe, 1'b1);
    open_kind = tps_pkg::KIND_OTHER;
    if (hold_phase != PH_APOS) begin
      add_piece(held_letter, 1'b1);
      open_kind = tps_pkg::KIND_LETTER;
    end
    hold_phase = PH_NONE;
  endfunction

  // Works out every result item that one accepted text item causes and appends
  // them to the expected results in release order.
  function automatic void predict_split(input logic [7:0] b, input logic last);
    logic [7:0] wanted;
    step_pieces.delete();
    case (hold_phase)
      PH_NONE: begin
        take_plain_byte(b);
      end
      PH_APOS: begin
        if (b == "s" || b == "t" || b == "m" || b == "d") begin
          add_piece(held_apostrophe, 1'b1);
          add_piece(b, 1'b0);
          open_kind  = tps_pkg::KIND_NONE;
          hold_phase = PH_NONE;
        end else if (b == "r" || b == "v" || b == "l") begin
          held_letter = b;
          hold_phase  = (b == "r") ? PH_APOS_R : ((b == "v") ? PH_APOS_V : PH_APOS_L);
        end else begin
          release_held_bytes();
          take_plain_byte(b);
        end
      end
      default: begin
        wanted = (hold_phase == PH_APOS_L) ? "l" : "e";
        if (b == wanted) begin
          add_piece(held_apostrophe, 1'b1);
          add_piece(held_letter, 1'b0);
          add_piece(b, 1'b0);
          open_kind  = tps_pkg::KIND_NONE;
          hold_phase = PH_NONE;
        end else begin
          release_held_bytes();
          take_plain_byte(b);
        end
      end
    endcase
    // The end of a text flushes whatever is held and starts the next text afresh.
    if (last) begin
      if (hold_phase != PH_NONE) begin
        release_held_bytes();
      end
      if (step_pieces.size() > 0) begin
        step_pieces[step_pieces.size() - 1].text_end = 1'b1;
      end
      open_kind  = tps_pkg::KIND_NONE;
      hold_phase = PH_NONE;
    end
    if (step_pieces.size() > 0) begin
      step_pieces[step_pieces.size() - 1].run_last = 1'b1;
    end
    foreach (step_pieces[i]) begin
      expected_pieces.insert(expected_pieces.size(), step_pieces[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Every result item taken by the receiver is compared with the oldest one due.
  always @(posedge clk_i) begin : check_results
    split_result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pieces.size() == 0) begin
        report_mismatch($sformatf("result item with byte %02h while none is due", out_byte_o));
      end else begin
        due = expected_pieces.pop_front();
        if (out_byte_o !== due.text_byte) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, due.text_byte));
        end
        if (token_start_o !== due.starts_token) begin
          report_mismatch($sformatf("token_start %b on byte %02h, expected %b",
                                    token_start_o, due.text_byte, due.starts_token));
        end
        if (run_last_o !== due.run_last) begin
          report_mismatch($sformatf("run_last %b on byte %02h, expected %b",
                                    run_last_o, due.text_byte, due.run_last));
        end
        if (text_end_o !== due.text_end) begin
          report_mismatch($sformatf("text_end %b on byte %02h, expected %b",
                                    text_end_o, due.text_byte, due.text_end));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold when the test asks for it.
  // The hold is counted here, independently of the sender, so the sender keeps
  // offering items until the queue inside the block is full.
  // ---------------------------------------------------------------------------
  always begin
    @(posedge clk_i);
    if (hold_output) begin
      out_stall_i <= 1'b1;
      for (int held = 0; held < HOLD_CYCLES; held++) begin
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      hold_output = 1'b0;
    end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Cycle counter that ends the run as failed once it reaches LIMIT_CYCLES.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one item, possibly after an idle burst, and waits until it is taken.
  // It is always entered at a rising edge and returns at the edge of acceptance.
  task automatic send_text_item(input logic [7:0] b, input logic last);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    text_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_split(b, last);
    items_sent++;
  endtask

  // Sends the text in text_bytes, marking its final byte as the end of the text.
  task automatic send_text();
    foreach (text_bytes[i]) begin
      send_text_item(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  // Withdraws the input and waits for every due result item, then for the drain period.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_pieces.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Appends one byte to the text being built.
  function automatic void add_text_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  // Builds a text from well-formed fragments with random content; a minority of
  // fragments are broken contractions or raw noise bytes.
  function automatic void make_random_text();
    int unsigned count;
    logic [7:0]  b;
    string       suffix;
    text_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      count = $urandom_range(1, 4);
      case (fragment_e'($urandom_range(0, 6)))
        FRAG_SPACE: begin
          repeat (count) begin
            case ($urandom_range(0, 3))
              0:       add_text_byte(" ");
              1:       add_text_byte(8'h09);
              2:       add_text_byte(8'h0A);
              default: add_text_byte(8'h0D);
            endcase
          end
        end
        FRAG_WORD: begin
          repeat (count) begin
            case ($urandom_range(0, 2))
              0:       add_text_byte(8'h41 + 8'($urandom_range(0, 25)));
              1:       add_text_byte(8'h61 + 8'($urandom_range(0, 25)));
              default: add_text_byte(8'h80 + 8'($urandom_range(0, 127)));
            endcase
          end
        end
        FRAG_NUMBER: begin
          repeat (count) add_text_byte(8'h30 + 8'($urandom_range(0, 9)));
        end
        FRAG_PUNCT: begin
          repeat (count) begin
            do begin
              b = 8'($urandom);
            end while (classify_byte(b) != tps_pkg::KIND_OTHER);
            add_text_byte(b);
          end
        end
        FRAG_CONTRACTION: begin
          suffix = contraction_suffix[$urandom_range(0, 6)];
          add_text_byte(APOSTROPHE);
          for (int i = 0; i < suffix.len(); i++) begin
            add_text_byte(suffix[i]);
          end
        end
        FRAG_BROKEN: begin
          // Apostrophe, perhaps a half-matched r, v or l, perhaps a random byte.
          add_text_byte(APOSTROPHE);
          if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 2))
              0:       add_text_byte("r");
              1:       add_text_byte("v");
              default: add_text_byte("l");
            endcase
          end
          if ($urandom_range(0, 3) != 0) begin
            add_text_byte(8'($urandom));
          end
        end
        default: begin
          repeat (count) add_text_byte(8'($urandom));
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every contraction in turn, closed by the end of the text on a completed one.
  task automatic test_contractions();
    text_bytes = '{APOSTROPHE, "s", APOSTROPHE, "t", APOSTROPHE, "m", APOSTROPHE, "d",
                   APOSTROPHE, "r", "e", APOSTROPHE, "v", "e", APOSTROPHE, "l", "l"};
    send_text();
    settle();
  endtask

  // Extreme byte values, two apostrophes in a row, failed contractions with and
  // without a held letter, an apostrophe as the final byte, and a held v that
  // only the end of the text releases.
  task automatic test_edge_cases();
    text_bytes = '{8'h00, 8'hFF, APOSTROPHE, APOSTROPHE, "r", 8'h80, APOSTROPHE, "l",
                   8'h7F, "9", 8'h0D, APOSTROPHE};
    send_text();
    text_bytes = '{8'h09, APOSTROPHE, "v"};
    send_text();
    settle();
  endtask

  // Random texts with idle bursts on both sides.
  task automatic test_random_texts();
    int unsigned goal;
    goal = items_sent + 30;
    while (items_sent < goal) begin
      make_random_text();
      send_text();
    end
    settle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items without gaps, so the block fills and stalls its input.
  task automatic test_output_hold();
    int unsigned goal;
    goal        = items_sent + 16;
    send_gaps   = 1'b0;
    hold_output = 1'b1;
    while (items_sent < goal) begin
      make_random_text();
      send_text();
    end
    settle();
  endtask

  // The last part of the run streams with no idling on either side.
  task automatic test_full_rate();
    int unsigned goal;
    goal        = items_sent + 20;
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    while (items_sent < goal) begin
      make_random_text();
      send_text();
    end
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_contractions();
    test_edge_cases();
    test_random_texts();
    test_output_hold();
    test_full_rate();
    if (mismatches == 0 && expected_pieces.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
